[rtl/bilinear_image_scaler_defines.svh]
// Assertion helpers for the bilinear image scaler.
`ifndef BILINEAR_IMAGE_SCALER_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define BIS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define BIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bis_pkg.sv]
package bis_pkg;

  // Frame store geometry and ratio precision
  localparam int MAX_SOURCE_WIDTH    = 256;
  localparam int MAX_SOURCE_HEIGHT   = 256;
  localparam int RATIO_FRACTION_BITS = 16;
  localparam int FRAC_W              = RATIO_FRACTION_BITS;

  // Fixed field widths
  localparam int SRC_REG_W  = 9;
  localparam int TGT_REG_W  = 13;
  localparam int OCOORD_W   = 12;
  localparam int LIDX_W     = 16;
  localparam int PIX_W      = 32;
  localparam int RGB_W      = 24;
  localparam int CH_W       = 8;
  localparam int NCH        = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Derived widths
  localparam int SX_W        = $clog2(MAX_SOURCE_WIDTH);
  localparam int SY_W        = $clog2(MAX_SOURCE_HEIGHT);
  localparam int SW_W        = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int SH_W        = $clog2(MAX_SOURCE_HEIGHT + 1);
  localparam int RATIO_W     = ((SX_W > SY_W) ? SX_W : SY_W) + FRAC_W;
  localparam int STORE_DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PX_W        = RATIO_W + OCOORD_W;
  localparam int PXI_W       = PX_W - FRAC_W;
  localparam int ROWP_W      = SY_W + SW_W;
  localparam int ROWSUM_W    = ROWP_W + 1;
  localparam int WT_W        = 2 * FRAC_W + 1;
  localparam int WFULL_W     = 2 * FRAC_W + 2;
  localparam int PROD_W      = CH_W + WT_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int DCNT_W      = $clog2(RATIO_W);

  // Neighbours per output pixel
  localparam int NBR   = 4;
  localparam int NBR_W = 2;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hff;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH,
    CFG_SOURCE_HEIGHT,
    CFG_TARGET_WIDTH,
    CFG_TARGET_HEIGHT
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD,
    OP_REQUEST
  } op_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_X,
    DIV_Y
  } div_state_t;

  typedef enum logic [2:0] {
    FRONT_IDLE,
    FRONT_MAP,
    FRONT_COORD,
    FRONT_ROW,
    FRONT_PUSH
  } front_state_t;

  typedef enum logic {
    BACK_IDLE,
    BACK_READ
  } back_state_t;

  // Clamped geometry derived from the registers
  typedef struct packed {
    logic [SW_W-1:0]      sw;
    logic [SH_W-1:0]      sh;
    logic [SX_W-1:0]      sw_m1;
    logic [SY_W-1:0]      sh_m1;
    logic [TGT_REG_W-1:0] tw;
    logic [TGT_REG_W-1:0] th;
  } geom_t;

  // Scale ratios, 8.16 style fixed point
  typedef struct packed {
    logic               ready;
    logic [RATIO_W-1:0] xr;
    logic [RATIO_W-1:0] yr;
  } ratio_t;

  // One queued command word
  typedef struct packed {
    op_t                         op;
    logic [NBR-1:0][ADDR_W-1:0]  addr;
    logic [RGB_W-1:0]            pixel;
    logic [FRAC_W-1:0]           fx;
    logic [FRAC_W-1:0]           fy;
  } qword_t;

  typedef struct packed {
    logic full;
    logic valid;
  } qstat_t;

endpackage

[rtl/bis_ram.sv]
module bis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [WIDTH-1:0]     wdata,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[rtl/bis_div.sv]
module bis_div import bis_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   restart,
  input  geom_t  geom,
  output ratio_t ratio
);

  div_state_t state, state_next;
  logic                 pending;
  logic [RATIO_W-1:0]   dvd, quo, xr, yr;
  logic [TGT_REG_W-1:0] dvs, rem;
  logic [DCNT_W-1:0]    cnt;
  logic [TGT_REG_W:0]   rem_sh;
  logic                 fits, last;
  logic [TGT_REG_W-1:0] rem_step;
  logic [RATIO_W-1:0]   quo_step;

  // one restoring step per cycle
  always_comb begin
    rem_sh   = {rem, dvd[RATIO_W-1]};
    fits     = rem_sh >= {1'b0, dvs};
    rem_step = fits ? TGT_REG_W'(rem_sh - {1'b0, dvs}) : rem_sh[TGT_REG_W-1:0];
    quo_step = {quo[RATIO_W-2:0], fits};
    last     = cnt == DCNT_W'(RATIO_W - 1);
  end

  // x ratio, then y ratio
  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE: if (pending) state_next = DIV_X;
      DIV_X:    if (last) state_next = DIV_Y;
      DIV_Y:    if (last) state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= DIV_IDLE;
      pending <= 1'b1;
    end else begin
      state <= state_next;
      // a register write during a run forces another run
      if (restart) begin
        pending <= 1'b1;
      end else if (state == DIV_IDLE) begin
        pending <= 1'b0;
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    unique case (state)
      DIV_IDLE: begin
        dvd <= RATIO_W'({geom.sw_m1, {FRAC_W{1'b0}}});
        dvs <= geom.tw;
        rem <= '0;
        cnt <= '0;
      end
      DIV_X: begin
        if (last) begin
          xr  <= quo_step;
          dvd <= RATIO_W'({geom.sh_m1, {FRAC_W{1'b0}}});
          dvs <= geom.th;
          rem <= '0;
          cnt <= '0;
        end else begin
          dvd <= dvd << 1;
          rem <= rem_step;
          quo <= quo_step;
          cnt <= cnt + DCNT_W'(1);
        end
      end
      DIV_Y: begin
        if (last) begin
          yr <= quo_step;
        end else begin
          dvd <= dvd << 1;
          rem <= rem_step;
          quo <= quo_step;
          cnt <= cnt + DCNT_W'(1);
        end
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

  always_comb begin
    ratio.ready = (state == DIV_IDLE) && !pending;
    ratio.xr    = xr;
    ratio.yr    = yr;
  end

endmodule

[rtl/bis_queue.sv]
module bis_queue import bis_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  qword_t push_word,
  input  logic   pop,
  output qstat_t qstat,
  output qword_t head
);

  qword_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_word;
  end

  assign head        = slots[rd_ptr];
  assign qstat.full  = count == QCNT_W'(QUEUE_DEPTH);
  assign qstat.valid = count != '0;

endmodule

[rtl/bis_front.sv]
module bis_front import bis_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                opcode,
  input  logic [LIDX_W-1:0]   load_index,
  input  logic [PIX_W-1:0]    load_pixel,
  input  logic [OCOORD_W-1:0] out_column,
  input  logic [OCOORD_W-1:0] out_row,
  input  logic                hold,
  input  geom_t               geom,
  input  ratio_t              ratio,
  input  qstat_t              qstat,
  output logic                busy,
  output logic                push,
  output qword_t              push_word
);

  front_state_t state, state_next;
  logic                 accept, load_ok;
  op_t                  op;
  logic [LIDX_W-1:0]    lidx;
  logic [RGB_W-1:0]     lpix;
  logic [OCOORD_W-1:0]  col, row, col_c, row_c;
  logic [TGT_REG_W-1:0] tw_m1, th_m1;
  logic [PX_W-1:0]      px, py;
  logic [PXI_W-1:0]     xi, yi;
  logic [SX_W-1:0]      x, x1, x_c, x1_c;
  logic [SY_W-1:0]      y, y1, y_c, y1_c;
  logic [FRAC_W-1:0]    fx, fy;
  logic [ROWP_W-1:0]    rowa, rowb;
  logic [ROWSUM_W-1:0]  sum_a, sum_b, sum_c, sum_d;

  // take a word when idle or while the last one is leaving
  assign busy    = hold || !ratio.ready ||
                   !((state == FRONT_IDLE) || ((state == FRONT_PUSH) && !qstat.full));
  assign accept  = start && !busy;
  assign load_ok = 32'(load_index) < 32'(STORE_DEPTH);

  // output coordinate saturated to the target size
  always_comb begin
    tw_m1 = geom.tw - TGT_REG_W'(1);
    th_m1 = geom.th - TGT_REG_W'(1);
    col_c = (TGT_REG_W'(out_column) > tw_m1) ? OCOORD_W'(tw_m1) : out_column;
    row_c = (TGT_REG_W'(out_row) > th_m1) ? OCOORD_W'(th_m1) : out_row;
  end

  // source position and right/lower neighbours
  always_comb begin
    xi   = px[PX_W-1:FRAC_W];
    yi   = py[PX_W-1:FRAC_W];
    x_c  = (xi > PXI_W'(geom.sw_m1)) ? geom.sw_m1 : SX_W'(xi);
    y_c  = (yi > PXI_W'(geom.sh_m1)) ? geom.sh_m1 : SY_W'(yi);
    x1_c = (x_c == geom.sw_m1) ? x_c : x_c + SX_W'(1);
    y1_c = (y_c == geom.sh_m1) ? y_c : y_c + SY_W'(1);
  end

  // next state and queue push
  always_comb begin
    state_next = state;
    push       = 1'b0;
    unique case (state)
      FRONT_IDLE:  state_next = FRONT_IDLE;
      FRONT_MAP:   state_next = FRONT_COORD;
      FRONT_COORD: state_next = FRONT_ROW;
      FRONT_ROW:   state_next = FRONT_PUSH;
      FRONT_PUSH: begin
        if (!qstat.full) begin
          push       = 1'b1;
          state_next = FRONT_IDLE;
        end
      end
      default:     state_next = FRONT_IDLE;
    endcase
    // loads beyond the store are dropped here
    if (accept) begin
      if (op_t'(opcode) == OP_REQUEST) begin
        state_next = FRONT_MAP;
      end else if (load_ok) begin
        state_next = FRONT_PUSH;
      end else begin
        state_next = FRONT_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FRONT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // front datapath, two multiplies in each of the map and row steps
  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= op_t'(opcode);
      lidx <= load_index;
      lpix <= load_pixel[RGB_W-1:0];
      col  <= col_c;
      row  <= row_c;
    end
    if (state == FRONT_MAP) begin
      px <= PX_W'(ratio.xr) * PX_W'(col);
      py <= PX_W'(ratio.yr) * PX_W'(row);
    end
    if (state == FRONT_COORD) begin
      x  <= x_c;
      x1 <= x1_c;
      y  <= y_c;
      y1 <= y1_c;
      fx <= px[FRAC_W-1:0];
      fy <= py[FRAC_W-1:0];
    end
    if (state == FRONT_ROW) begin
      rowa <= ROWP_W'(y) * ROWP_W'(geom.sw);
      rowb <= ROWP_W'(y1) * ROWP_W'(geom.sw);
    end
  end

  // linear addresses wrap modulo the store depth
  always_comb begin
    sum_a = ROWSUM_W'(rowa) + ROWSUM_W'(x);
    sum_b = ROWSUM_W'(rowa) + ROWSUM_W'(x1);
    sum_c = ROWSUM_W'(rowb) + ROWSUM_W'(x);
    sum_d = ROWSUM_W'(rowb) + ROWSUM_W'(x1);
    push_word.op    = op;
    push_word.pixel = lpix;
    push_word.fx    = fx;
    push_word.fy    = fy;
    if (op == OP_LOAD) begin
      push_word.addr[0] = ADDR_W'(lidx);
      push_word.addr[1] = ADDR_W'(lidx);
      push_word.addr[2] = ADDR_W'(lidx);
      push_word.addr[3] = ADDR_W'(lidx);
    end else begin
      push_word.addr[0] = sum_a[ADDR_W-1:0];
      push_word.addr[1] = sum_b[ADDR_W-1:0];
      push_word.addr[2] = sum_c[ADDR_W-1:0];
      push_word.addr[3] = sum_d[ADDR_W-1:0];
    end
  end

endmodule

[rtl/bis_back.sv]
module bis_back import bis_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  qstat_t           qstat,
  input  qword_t           head,
  output logic             pop,
  output logic             done,
  output logic [PIX_W-1:0] out_pixel
);

  localparam logic [NBR_W-1:0] LAST_SLOT = NBR_W'(NBR - 1);

  back_state_t state, state_next;
  qword_t            cur;
  logic [NBR_W-1:0]  slot;
  logic              take_req;
  logic              ram_en, ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [RGB_W-1:0]  ram_rdata;

  // read return
  logic              rd_valid;
  logic [NBR_W-1:0]  rd_slot;
  logic [FRAC_W-1:0] rd_fx, rd_fy;
  logic [RGB_W-1:0]  pix_cap [NBR-1];
  logic [FRAC_W:0]   ofx, ofy;
  logic [WFULL_W-1:0] wt_full [NBR];

  // blend pipeline
  logic              b1_valid, b2_valid;
  logic [RGB_W-1:0]  b1_pix [NBR];
  logic [WT_W-1:0]   b1_wt [NBR];
  logic [PROD_W-1:0] b2_prod [NCH][NBR];
  logic [SUM_W-1:0]  ch_sum [NCH];
  logic [CH_W-1:0]   chan [NCH];

  // sequencer: loads write at once, requests take four reads
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    take_req   = 1'b0;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = head.addr[0];
    unique case (state)
      BACK_IDLE: begin
        if (qstat.valid) begin
          pop = 1'b1;
          if (head.op == OP_LOAD) begin
            ram_en = 1'b1;
            ram_we = 1'b1;
          end else begin
            take_req   = 1'b1;
            state_next = BACK_READ;
          end
        end
      end
      BACK_READ: begin
        ram_en   = 1'b1;
        ram_addr = cur.addr[slot];
        if (slot == LAST_SLOT) begin
          if (qstat.valid && (head.op == OP_REQUEST)) begin
            pop      = 1'b1;
            take_req = 1'b1;
          end else begin
            state_next = BACK_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BACK_IDLE;
      slot     <= '0;
      rd_valid <= 1'b0;
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      if (take_req) begin
        slot <= '0;
      end else if (state == BACK_READ) begin
        slot <= slot + NBR_W'(1);
      end
      rd_valid <= state == BACK_READ;
      b1_valid <= rd_valid && (rd_slot == LAST_SLOT);
      b2_valid <= b1_valid;
      done     <= b2_valid;
    end
  end

  bis_ram #(
    .WIDTH(RGB_W),
    .DEPTH(STORE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(head.pixel),
    .rdata(ram_rdata)
  );

  // bilinear weights, each at most 2^(2F)
  always_comb begin
    ofx        = {1'b1, {FRAC_W{1'b0}}} - {1'b0, rd_fx};
    ofy        = {1'b1, {FRAC_W{1'b0}}} - {1'b0, rd_fy};
    wt_full[0] = WFULL_W'(ofx) * WFULL_W'(ofy);
    wt_full[1] = WFULL_W'({1'b0, rd_fx}) * WFULL_W'(ofy);
    wt_full[2] = WFULL_W'({1'b0, rd_fy}) * WFULL_W'(ofx);
    wt_full[3] = WFULL_W'({1'b0, rd_fx}) * WFULL_W'({1'b0, rd_fy});
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (take_req) cur <= head;
    rd_slot <= slot;
    if ((state == BACK_READ) && (slot == LAST_SLOT)) begin
      rd_fx <= cur.fx;
      rd_fy <= cur.fy;
    end
    if (rd_valid && (rd_slot != LAST_SLOT)) begin
      pix_cap[rd_slot] <= ram_rdata;
    end
    // stage 1: gather neighbours, weights
    if (rd_valid && (rd_slot == LAST_SLOT)) begin
      for (int n = 0; n < NBR - 1; n++) begin
        b1_pix[n] <= pix_cap[n];
      end
      b1_pix[NBR-1] <= ram_rdata;
      for (int n = 0; n < NBR; n++) begin
        b1_wt[n] <= wt_full[n][WT_W-1:0];
      end
    end
    // stage 2: channel times weight
    for (int c = 0; c < NCH; c++) begin
      for (int n = 0; n < NBR; n++) begin
        b2_prod[c][n] <= PROD_W'(b1_pix[n][c*CH_W +: CH_W]) * PROD_W'(b1_wt[n]);
      end
    end
    // stage 3: sum and truncate
    out_pixel <= {ALPHA_OPAQUE, chan[2], chan[1], chan[0]};
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      ch_sum[c] = SUM_W'(b2_prod[c][0]) + SUM_W'(b2_prod[c][1]) +
                  SUM_W'(b2_prod[c][2]) + SUM_W'(b2_prod[c][3]);
      chan[c]   = ch_sum[c][2*FRAC_W +: CH_W];
    end
  end

endmodule

[rtl/bilinear_image_scaler.sv]
// Bilinear ARGB8888 scaler. Source pixels are written into a 256 x 256 frame
// store with load words (opcode 0); request words (opcode 1) return one
// blended pixel with alpha 0xff on out_pixel, marked by done for exactly one
// cycle, in request order. done cannot be held off, so take it when it shows.
// A load is taken every cycle while the command queue has room and no
// register write or ratio recompute holds busy. A request passes the front
// steps map, coordinate, row and push (the map and row steps multiply), and
// in the back reads its four neighbours one after another from the
// single-port frame memory. After reset and after every register write the
// scale ratios are recomputed by a serial divider, one quotient bit a cycle,
// x ratio first, then y ratio; busy stays high until both are done.
// Store entries hold garbage until loaded; there is no clearing pass.
`include "bilinear_image_scaler_defines.svh"

module bilinear_image_scaler import bis_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  opcode,
  input  logic [LIDX_W-1:0]     load_index,
  input  logic [PIX_W-1:0]      load_pixel,
  input  logic [OCOORD_W-1:0]   out_column,
  input  logic [OCOORD_W-1:0]   out_row,
  output logic                  done,
  output logic [PIX_W-1:0]      out_pixel,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [SRC_REG_W-1:0] source_width, source_height;
  logic [TGT_REG_W-1:0] target_width, target_height;
  logic   cfg_write;
  geom_t  geom;
  ratio_t ratio;
  qstat_t qstat;
  qword_t q_word, q_head;
  logic   q_push, q_pop;

  // register write channel
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SRC_REG_W'(256);
      source_height <= SRC_REG_W'(256);
      target_width  <= TGT_REG_W'(256);
      target_height <= TGT_REG_W'(256);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SOURCE_WIDTH:  source_width  <= cfg_data[SRC_REG_W-1:0];
        CFG_SOURCE_HEIGHT: source_height <= cfg_data[SRC_REG_W-1:0];
        CFG_TARGET_WIDTH:  target_width  <= cfg_data[TGT_REG_W-1:0];
        CFG_TARGET_HEIGHT: target_height <= cfg_data[TGT_REG_W-1:0];
      endcase
    end
  end

  // source size clamped to 2..max, target size zero taken as one
  always_comb begin
    if (source_width < SRC_REG_W'(2)) begin
      geom.sw = SW_W'(2);
    end else if (32'(source_width) > 32'(MAX_SOURCE_WIDTH)) begin
      geom.sw = SW_W'(MAX_SOURCE_WIDTH);
    end else begin
      geom.sw = SW_W'(source_width);
    end
    if (source_height < SRC_REG_W'(2)) begin
      geom.sh = SH_W'(2);
    end else if (32'(source_height) > 32'(MAX_SOURCE_HEIGHT)) begin
      geom.sh = SH_W'(MAX_SOURCE_HEIGHT);
    end else begin
      geom.sh = SH_W'(source_height);
    end
    geom.sw_m1 = SX_W'(geom.sw - SW_W'(1));
    geom.sh_m1 = SY_W'(geom.sh - SH_W'(1));
    geom.tw    = (target_width == '0) ? TGT_REG_W'(1) : target_width;
    geom.th    = (target_height == '0) ? TGT_REG_W'(1) : target_height;
  end

  bis_div u_div (
    .clk    (clk),
    .rst    (rst),
    .restart(cfg_write),
    .geom   (geom),
    .ratio  (ratio)
  );

  bis_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .opcode    (opcode),
    .load_index(load_index),
    .load_pixel(load_pixel),
    .out_column(out_column),
    .out_row   (out_row),
    .hold      (cfg_write),
    .geom      (geom),
    .ratio     (ratio),
    .qstat     (qstat),
    .busy      (busy),
    .push      (q_push),
    .push_word (q_word)
  );

  bis_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_word(q_word),
    .pop      (q_pop),
    .qstat    (qstat),
    .head     (q_head)
  );

  bis_back u_back (
    .clk      (clk),
    .rst      (rst),
    .qstat    (qstat),
    .head     (q_head),
    .pop      (q_pop),
    .done     (done),
    .out_pixel(out_pixel)
  );

  // checks
  `BIS_ASSERT_IMPL(a_accept_needs_ratio, start && !busy, ratio.ready && !cfg_write, "early accept")
  `BIS_ASSERT_IMPL(a_no_push_when_full, q_push, !qstat.full, "queue pushed while full")
  `BIS_ASSERT_IMPL(a_no_pop_when_empty, q_pop, qstat.valid, "queue popped while empty")
  `BIS_ASSERT_NEXT(a_write_reruns_div, cfg_write, !ratio.ready, "ratios not recomputed")

endmodule
